// File: hw/rtl/i2c_bit_level_master_core_macros.svh
// Assertion macros for the I2C bit-level master core.
`ifndef I2C_BIT_LEVEL_MASTER_CORE_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define I2CBM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("i2cbm assertion failed");
// Next-cycle implication, disabled during reset.
`define I2CBM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i2cbm assertion failed");
`else
`define I2CBM_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define I2CBM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/i2cbm_pkg.sv
`timescale 1ns / 1ps
package i2cbm_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

    // Phase codes
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START1  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_START2  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_STOP1   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_STOP2   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_LOW  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_HIGH = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WR_TAIL = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RD_LOW  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_HIGH = 4'd9;
    localparam logic [PHASE_W-1:0] PH_AK_LOW  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_AK_HIGH = 4'd11;
    localparam logic [PHASE_W-1:0] PH_WA1     = 4'd12;
    localparam logic [PHASE_W-1:0] PH_WA2     = 4'd13;
    localparam logic [PHASE_W-1:0] PH_WA_POLL = 4'd14;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_LIMIT   = 1'd1;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
    localparam logic [7:0] ACK_LIMIT_RESET   = 8'd200;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_word_t;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] ack_wait_limit;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [7:0]         delay_count;
        logic [3:0]         bit_count;
        logic [7:0]         shift_reg;
        logic [7:0]         ack_wait_count;
        logic               scl;
        logic               sda;
        logic               ack_choice;
        logic               fail_flag;
        logic [7:0]         rx_hold;
    } core_state_t;

    localparam core_state_t STATE_RESET = '{
        phase:          PH_IDLE,
        delay_count:    8'd0,
        bit_count:      4'd0,
        shift_reg:      8'd0,
        ack_wait_count: 8'd0,
        scl:            1'b1,
        sda:            1'b1,
        ack_choice:     1'b0,
        fail_flag:      1'b0,
        rx_hold:        8'd0
    };

endpackage

// File: hw/rtl/i2cbm_step.sv
`timescale 1ns / 1ps
// One step of the bus sequencer: next state and result word for one input word.
module i2cbm_step (
    input  i2cbm_pkg::core_state_t st,
    input  i2cbm_pkg::cfg_t        cfg,
    input  i2cbm_pkg::in_word_t    in_word,
    output i2cbm_pkg::core_state_t st_next,
    output i2cbm_pkg::out_word_t   out_word
);

    logic       done;
    logic [3:0] bit_inc;
    logic [7:0] ack_inc;

    assign bit_inc = st.bit_count + 4'd1;
    assign ack_inc = st.ack_wait_count + 8'd1;

    always_comb begin
        st_next = st;
        done    = 1'b0;
        if (st.phase == i2cbm_pkg::PH_IDLE) begin
            // Idle: take a command
            case (in_word.cmd)
                i2cbm_pkg::CMD_START: begin
                    st_next.sda         = 1'b1;
                    st_next.scl         = 1'b1;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_START1;
                end
                i2cbm_pkg::CMD_STOP: begin
                    st_next.scl         = 1'b0;
                    st_next.sda         = 1'b0;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_STOP1;
                end
                i2cbm_pkg::CMD_WRITE: begin
                    st_next.scl         = 1'b0;
                    st_next.sda         = in_word.tx_byte[7];
                    st_next.shift_reg   = {in_word.tx_byte[6:0], 1'b0};
                    st_next.bit_count   = 4'd0;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_WR_LOW;
                end
                i2cbm_pkg::CMD_READ: begin
                    st_next.ack_choice  = in_word.send_ack;
                    st_next.scl         = 1'b0;
                    st_next.sda         = 1'b1;
                    st_next.shift_reg   = 8'd0;
                    st_next.bit_count   = 4'd0;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_RD_LOW;
                end
                i2cbm_pkg::CMD_WAIT_ACK: begin
                    st_next.fail_flag   = 1'b0;
                    st_next.sda         = 1'b1;
                    st_next.delay_count = 8'd1;
                    st_next.phase       = i2cbm_pkg::PH_WA1;
                end
                default: begin
                end
            endcase
        end else if (st.phase == i2cbm_pkg::PH_WA_POLL) begin
            // ACK poll: SDA low ends it, otherwise count toward timeout and stop
            if (!in_word.sda_in) begin
                st_next.scl   = 1'b0;
                st_next.phase = i2cbm_pkg::PH_IDLE;
                done          = 1'b1;
            end else begin
                st_next.ack_wait_count = ack_inc;
                if (ack_inc >= cfg.ack_wait_limit) begin
                    st_next.fail_flag   = 1'b1;
                    st_next.scl         = 1'b0;
                    st_next.sda         = 1'b0;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_STOP1;
                end
            end
        end else if (st.delay_count > 8'd1) begin
            // Delay still running
            st_next.delay_count = st.delay_count - 8'd1;
        end else begin
            // Delay expired: next bus edge on this tick
            st_next.delay_count = 8'd0;
            case (st.phase)
                i2cbm_pkg::PH_START1: begin
                    st_next.sda         = 1'b0;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_START2;
                end
                i2cbm_pkg::PH_START2: begin
                    st_next.scl   = 1'b0;
                    st_next.phase = i2cbm_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                i2cbm_pkg::PH_STOP1: begin
                    st_next.scl         = 1'b1;
                    st_next.sda         = 1'b1;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_STOP2;
                end
                i2cbm_pkg::PH_STOP2: begin
                    st_next.phase = i2cbm_pkg::PH_IDLE;
                    done          = 1'b1;
                end
                i2cbm_pkg::PH_WR_LOW: begin
                    st_next.scl         = 1'b1;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_WR_HIGH;
                end
                i2cbm_pkg::PH_WR_HIGH: begin
                    st_next.scl         = 1'b0;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_WR_TAIL;
                end
                i2cbm_pkg::PH_WR_TAIL: begin
                    st_next.bit_count = bit_inc;
                    if (bit_inc >= i2cbm_pkg::BITS_PER_BYTE) begin
                        st_next.phase = i2cbm_pkg::PH_IDLE;
                        done          = 1'b1;
                    end else begin
                        st_next.sda         = st.shift_reg[7];
                        st_next.shift_reg   = {st.shift_reg[6:0], 1'b0};
                        st_next.delay_count = cfg.half_period_ticks;
                        st_next.phase       = i2cbm_pkg::PH_WR_LOW;
                    end
                end
                i2cbm_pkg::PH_RD_LOW: begin
                    st_next.scl         = 1'b1;
                    st_next.shift_reg   = {st.shift_reg[6:0], in_word.sda_in};
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_RD_HIGH;
                end
                i2cbm_pkg::PH_RD_HIGH: begin
                    st_next.bit_count   = bit_inc;
                    st_next.scl         = 1'b0;
                    st_next.delay_count = cfg.half_period_ticks;
                    if (bit_inc < i2cbm_pkg::BITS_PER_BYTE) begin
                        st_next.phase = i2cbm_pkg::PH_RD_LOW;
                    end else begin
                        st_next.sda   = ~st.ack_choice;
                        st_next.phase = i2cbm_pkg::PH_AK_LOW;
                    end
                end
                i2cbm_pkg::PH_AK_LOW: begin
                    st_next.scl         = 1'b1;
                    st_next.delay_count = cfg.half_period_ticks;
                    st_next.phase       = i2cbm_pkg::PH_AK_HIGH;
                end
                i2cbm_pkg::PH_AK_HIGH: begin
                    st_next.scl     = 1'b0;
                    st_next.rx_hold = st.shift_reg;
                    st_next.phase   = i2cbm_pkg::PH_IDLE;
                    done            = 1'b1;
                end
                i2cbm_pkg::PH_WA1: begin
                    st_next.scl         = 1'b1;
                    st_next.delay_count = 8'd1;
                    st_next.phase       = i2cbm_pkg::PH_WA2;
                end
                i2cbm_pkg::PH_WA2: begin
                    st_next.ack_wait_count = 8'd0;
                    st_next.phase          = i2cbm_pkg::PH_WA_POLL;
                end
                default: begin
                    st_next.phase = i2cbm_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result word reflects the state after the step
    assign out_word.scl_level  = st_next.scl;
    assign out_word.sda_level  = st_next.sda;
    assign out_word.busy_res   = (st_next.phase != i2cbm_pkg::PH_IDLE);
    assign out_word.done_res   = done;
    assign out_word.rx_byte    = st_next.rx_hold;
    assign out_word.ack_failed = st_next.fail_flag;

endmodule

// File: hw/rtl/i2c_bit_level_master_core.sv
`timescale 1ns / 1ps
// I2C bit-level master. Every input word on s_ is one step: a timing tick, or
// while idle a command (start, stop, write byte, read byte, wait ACK). Commands
// that arrive while busy count as plain ticks. Each input word yields exactly
// one result word on m_ with the SCL/SDA levels to drive, busy, a done pulse,
// the last read byte and the ACK-failure flag.
// The result appears in the cycle after the input word is accepted; the
// sequencer step is one combinational pass into the state and result registers.
// Throughput: one word per cycle; s_ready stays high while the result register
// is empty or being taken, so a stalled m_ side holds the block after one word.
// Configuration (cfg_we/cfg_index/cfg_data) sets the half-period in ticks
// (index 0) and the ACK poll limit in ticks (index 1); write only while idle.
// Reset (aresetn low, synchronous): bus released (SCL=SDA=1), phase idle,
// half-period 5, ACK limit 200, no result pending.
`include "i2c_bit_level_master_core_macros.svh"
module i2c_bit_level_master_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  i2cbm_pkg::in_word_t                  s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output i2cbm_pkg::out_word_t                 m_data
);

    i2cbm_pkg::core_state_t state_reg, state_next;
    i2cbm_pkg::cfg_t        cfg_reg;
    i2cbm_pkg::out_word_t   out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    i2cbm_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .in_word (s_data),
        .st_next (state_next),
        .out_word(out_next)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= i2cbm_pkg::HALF_PERIOD_RESET;
            cfg_reg.ack_wait_limit    <= i2cbm_pkg::ACK_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                i2cbm_pkg::REG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data;
                i2cbm_pkg::REG_ACK_LIMIT:   cfg_reg.ack_wait_limit    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state advances once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2cbm_pkg::STATE_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // Result register
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Checks
    `I2CBM_ASSERT_IMPL(a_done_not_busy, aclk, aresetn, m_valid && m_data.done_res, !m_data.busy_res)
    `I2CBM_ASSERT_NEXT(a_busy_tracks_phase, aclk, aresetn, accept, m_data.busy_res == (state_reg.phase != i2cbm_pkg::PH_IDLE))
    `I2CBM_ASSERT_NEXT(a_start_releases, aclk, aresetn, accept && (state_reg.phase == i2cbm_pkg::PH_IDLE) && (s_data.cmd == i2cbm_pkg::CMD_START), m_valid && m_data.busy_res && m_data.scl_level && m_data.sda_level)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import i2cbm_pkg::*;

    // Codes the block treats as a plain tick
    localparam logic [2:0] CMD_RSVD_LO = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 50;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_word_t              m_data;

    i2c_bit_level_master_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Mirror of the bus sequencer
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [7:0]         delay;
        logic [3:0]         bits;
        logic [7:0]         shreg;
        logic [7:0]         polls;
        logic               scl;
        logic               sda;
        logic               ack_sel;
        logic               nack_seen;
        logic [7:0]         last_rx;
    } bus_model_t;

    bus_model_t bus;
    logic [7:0] half_ticks;
    logic [7:0] poll_limit;

    out_word_t  pending_results[$];
    int         fail_count;
    int         words_sent;
    int         results_seen;
    int         timeouts_seen;
    int         cmd_seen [8];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_requests;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic void load_half(logic [PHASE_W-1:0] next_phase);
        bus.delay = half_ticks;
        bus.phase = next_phase;
    endfunction

    function automatic void shift_out_bit();
        bus.sda   = bus.shreg[7];
        bus.shreg = {bus.shreg[6:0], 1'b0};
    endfunction

    function automatic void drive_stop();
        bus.scl = 1'b0;
        bus.sda = 1'b0;
        load_half(PH_STOP1);
    endfunction

    // One tick of a busy sequence; returns 1 when the command completes
    function automatic logic advance_bus(logic sda_in);
        if (bus.phase == PH_WA_POLL) begin
            if (!sda_in) begin
                bus.scl   = 1'b0;
                bus.phase = PH_IDLE;
                return 1'b1;
            end
            bus.polls = bus.polls + 8'd1;
            if (bus.polls >= poll_limit) begin
                bus.nack_seen = 1'b1;
                timeouts_seen++;
                drive_stop();
            end
            return 1'b0;
        end
        // zero half period behaves as one tick
        if (bus.delay > 8'd1) begin
            bus.delay = bus.delay - 8'd1;
            return 1'b0;
        end
        bus.delay = 8'd0;
        case (bus.phase)
            PH_START1: begin
                bus.sda = 1'b0;
                load_half(PH_START2);
            end
            PH_START2: begin
                bus.scl   = 1'b0;
                bus.phase = PH_IDLE;
                return 1'b1;
            end
            PH_STOP1: begin
                bus.scl = 1'b1;
                bus.sda = 1'b1;
                load_half(PH_STOP2);
            end
            PH_STOP2: begin
                bus.phase = PH_IDLE;
                return 1'b1;
            end
            PH_WR_LOW: begin
                bus.scl = 1'b1;
                load_half(PH_WR_HIGH);
            end
            PH_WR_HIGH: begin
                bus.scl = 1'b0;
                load_half(PH_WR_TAIL);
            end
            PH_WR_TAIL: begin
                bus.bits = bus.bits + 4'd1;
                if (bus.bits >= BITS_PER_BYTE) begin
                    bus.phase = PH_IDLE;
                    return 1'b1;
                end
                shift_out_bit();
                load_half(PH_WR_LOW);
            end
            PH_RD_LOW: begin
                bus.scl   = 1'b1;
                bus.shreg = {bus.shreg[6:0], sda_in};
                load_half(PH_RD_HIGH);
            end
            PH_RD_HIGH: begin
                bus.bits = bus.bits + 4'd1;
                bus.scl  = 1'b0;
                if (bus.bits < BITS_PER_BYTE) begin
                    load_half(PH_RD_LOW);
                end else begin
                    bus.sda = ~bus.ack_sel;
                    load_half(PH_AK_LOW);
                end
            end
            PH_AK_LOW: begin
                bus.scl = 1'b1;
                load_half(PH_AK_HIGH);
            end
            PH_AK_HIGH: begin
                bus.scl     = 1'b0;
                bus.last_rx = bus.shreg;
                bus.phase   = PH_IDLE;
                return 1'b1;
            end
            PH_WA1: begin
                bus.scl   = 1'b1;
                bus.delay = 8'd1;
                bus.phase = PH_WA2;
            end
            PH_WA2: begin
                bus.polls = 8'd0;
                bus.phase = PH_WA_POLL;
            end
            default: bus.phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    // Expected result word for one accepted input word
    function automatic out_word_t predict_word(in_word_t w);
        logic      done;
        out_word_t r;
        done = 1'b0;
        if (bus.phase == PH_IDLE) begin
            cmd_seen[w.cmd]++;
            case (w.cmd)
                CMD_START: begin
                    bus.sda = 1'b1;
                    bus.scl = 1'b1;
                    load_half(PH_START1);
                end
                CMD_STOP: drive_stop();
                CMD_WRITE: begin
                    bus.scl   = 1'b0;
                    bus.shreg = w.tx_byte;
                    bus.bits  = 4'd0;
                    shift_out_bit();
                    load_half(PH_WR_LOW);
                end
                CMD_READ: begin
                    bus.ack_sel = w.send_ack;
                    bus.scl     = 1'b0;
                    bus.sda     = 1'b1;
                    bus.shreg   = 8'd0;
                    bus.bits    = 4'd0;
                    load_half(PH_RD_LOW);
                end
                CMD_WAIT_ACK: begin
                    bus.nack_seen = 1'b0;
                    bus.sda       = 1'b1;
                    bus.delay     = 8'd1;
                    bus.phase     = PH_WA1;
                end
                default: ;
            endcase
        end else begin
            done = advance_bus(w.sda_in);
        end
        r.scl_level  = bus.scl;
        r.sda_level  = bus.sda;
        r.busy_res   = (bus.phase != PH_IDLE);
        r.done_res   = done;
        r.rx_byte    = bus.last_rx;
        r.ack_failed = bus.nack_seen;
        return r;
    endfunction

    // Offer one word, with random sender gaps, and log its expected result
    task automatic send_word(in_word_t w);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_word(w));
        words_sent++;
    endtask

    // Tick until the sequencer is idle; some ticks carry junk commands
    task automatic settle(int low_pct);
        in_word_t w;
        while (bus.phase != PH_IDLE) begin
            w.cmd      = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : CMD_TICK;
            w.tx_byte  = 8'($urandom);
            w.send_ack = 1'($urandom);
            w.sda_in   = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
            send_word(w);
        end
    endtask

    task automatic issue(logic [2:0] cmd, logic [7:0] tx, logic ack, int low_pct);
        in_word_t w;
        w.cmd      = cmd;
        w.tx_byte  = tx;
        w.send_ack = ack;
        w.sda_in   = 1'($urandom);
        send_word(w);
        settle(low_pct);
    endtask

    // Register write with the sequencer idle and no result in flight
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        settle(50);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_HALF_PERIOD) half_ticks = val;
        else poll_limit = val;
    endtask

    // Start, a few written bytes with ACK polls, some reads, stop
    task automatic i2c_transfer();
        logic acked;
        acked = 1'b1;
        issue(CMD_START, 8'($urandom), 1'($urandom), 50);
        repeat ($urandom_range(1, 3)) begin
            if (acked) begin
                issue(CMD_WRITE, 8'($urandom), 1'($urandom), 50);
                issue(CMD_WAIT_ACK, 8'($urandom), 1'($urandom),
                      ($urandom_range(0, 3) == 0) ? 0 : 25);
                acked = ~bus.nack_seen;
            end
        end
        // a timed-out ACK has already released the bus
        if (acked) begin
            repeat ($urandom_range(0, 2))
                issue(CMD_READ, 8'($urandom), 1'($urandom), $urandom_range(0, 100));
            issue(CMD_STOP, 8'($urandom), 1'($urandom), 50);
        end
    endtask

    task automatic test_bus_conditions();
        issue(CMD_START, 8'h00, 1'b0, 50);
        issue(CMD_STOP, 8'hFF, 1'b1, 50);
    endtask

    task automatic test_write_bytes();
        // short half period keeps the directed byte tests brief
        write_reg(REG_HALF_PERIOD, 8'd1);
        issue(CMD_START, 8'h00, 1'b0, 50);
        issue(CMD_WRITE, 8'hFF, 1'b0, 50);
        issue(CMD_WRITE, 8'h00, 1'b1, 50);
        issue(CMD_WRITE, 8'h80, 1'b0, 50);
        issue(CMD_WRITE, 8'h01, 1'b1, 50);
        issue(CMD_STOP, 8'h00, 1'b0, 50);
    endtask

    task automatic test_read_bytes();
        issue(CMD_START, 8'h00, 1'b0, 50);
        issue(CMD_READ, 8'h00, 1'b1, 0);
        issue(CMD_READ, 8'hFF, 1'b0, 100);
        issue(CMD_READ, 8'h5A, 1'b1, 50);
        issue(CMD_STOP, 8'h00, 1'b0, 50);
    endtask

    task automatic test_ack_wait();
        issue(CMD_START, 8'h00, 1'b0, 50);
        issue(CMD_WRITE, 8'hA5, 1'b0, 50);
        // ACK seen on the first polled tick
        issue(CMD_WAIT_ACK, 8'h00, 1'b0, 100);
        issue(CMD_WRITE, 8'h5A, 1'b1, 50);
        // SDA never low: full poll at the reset limit, then stop
        issue(CMD_WAIT_ACK, 8'hFF, 1'b1, 0);
    endtask

    task automatic test_odd_codes();
        in_word_t w;
        issue(CMD_TICK, 8'hFF, 1'b1, 50);
        issue(CMD_RSVD_LO, 8'h00, 1'b0, 50);
        issue(CMD_RSVD_HI, 8'hFF, 1'b1, 50);
        // a write offered while start is running must act as a tick
        w.cmd      = CMD_START;
        w.tx_byte  = 8'h00;
        w.send_ack = 1'b0;
        w.sda_in   = 1'b1;
        send_word(w);
        w.cmd      = CMD_WRITE;
        w.tx_byte  = 8'hC3;
        w.sda_in   = 1'b0;
        send_word(w);
        settle(50);
        issue(CMD_STOP, 8'h00, 1'b0, 50);
    endtask

    task automatic test_config_extremes();
        // zero half period and zero ACK limit
        write_reg(REG_HALF_PERIOD, 8'd0);
        write_reg(REG_ACK_LIMIT, 8'd0);
        issue(CMD_START, 8'h00, 1'b0, 50);
        issue(CMD_WRITE, 8'h3C, 1'b0, 50);
        issue(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
        issue(CMD_READ, 8'h00, 1'b1, 50);
        issue(CMD_STOP, 8'h00, 1'b0, 50);
        // widest ACK limit, polled to the end
        write_reg(REG_ACK_LIMIT, 8'd255);
        write_reg(REG_HALF_PERIOD, 8'd1);
        issue(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    endtask

    // Long receiver hold-off while a read is streamed in back to back
    task automatic test_backpressure();
        write_reg(REG_HALF_PERIOD, 8'd2);
        write_reg(REG_ACK_LIMIT, 8'd8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        issue(CMD_START, 8'h00, 1'b0, 50);
        issue(CMD_READ, 8'h00, 1'b1, 50);
        issue(CMD_STOP, 8'h00, 1'b0, 50);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, logic [7:0] hp,
                                       logic [7:0] lim, int words);
        int stop_at;
        write_reg(REG_HALF_PERIOD, hp);
        write_reg(REG_ACK_LIMIT, lim);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0)
                issue(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                      $urandom_range(0, 100));
            else
                i2c_transfer();
        end
    endtask

    // Receiver: random stalls, plus an occasional long hold-off
    initial begin
        int served;
        int left;
        served  = 0;
        left    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (left == 0 && served != hold_requests) begin
                served++;
                left = HOLD_CYCLES;
            end
            if (left > 0) begin
                left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected result word: expected none, got %p",
                             $time, m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("scl_level", 8'(want.scl_level), 8'(m_data.scl_level));
                check_field("sda_level", 8'(want.sda_level), 8'(m_data.sda_level));
                check_field("busy_res", 8'(want.busy_res), 8'(m_data.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(m_data.done_res));
                check_field("rx_byte", want.rx_byte, m_data.rx_byte);
                check_field("ack_failed", 8'(want.ack_failed), 8'(m_data.ack_failed));
            end
        end
    end

    initial begin
        int n;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        fail_count     = 0;
        words_sent     = 0;
        results_seen   = 0;
        timeouts_seen  = 0;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        bus = '{phase: PH_IDLE, delay: 8'd0, bits: 4'd0, shreg: 8'd0, polls: 8'd0,
                scl: 1'b1, sda: 1'b1, ack_sel: 1'b0, nack_seen: 1'b0, last_rx: 8'd0};
        half_ticks = HALF_PERIOD_RESET;
        poll_limit = ACK_LIMIT_RESET;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_bus_conditions();
        test_write_bytes();
        test_read_bytes();
        test_ack_wait();
        test_odd_codes();
        test_config_extremes();
        test_backpressure();
        test_random_traffic(0, 0, 8'd1, 8'd4, 140);
        test_random_traffic(46, 0, 8'd2, 8'd12, 140);
        test_random_traffic(0, 46, 8'd4, 8'd1, 140);
        test_random_traffic(12, 12, 8'($urandom_range(1, 3)), 8'd30, 140);

        // drain
        @(negedge aclk);
        s_valid = 1'b0;
        for (n = 0; n < 20000 && pending_results.size() != 0; n++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending_results.size());
            fail_count++;
        end

        $display("Run covered %0d input words and %0d checked results over four traffic mixes",
                 words_sent, results_seen);
        $display("Commands: %0d start, %0d stop, %0d write, %0d read, %0d wait-ack",
                 cmd_seen[CMD_START], cmd_seen[CMD_STOP], cmd_seen[CMD_WRITE],
                 cmd_seen[CMD_READ], cmd_seen[CMD_WAIT_ACK]);
        $display("ACK timeouts: %0d", timeouts_seen);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
